FILE: rtl/dmps_pkg.sv
package dmps_pkg;

    localparam int WINDOW_WIDTH = 16;

    localparam int CFG_IDX_WIDTH  = 3;
    localparam int CFG_DATA_WIDTH = 16;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_DEBOUNCE_LIMIT = 3'd0,
        CFG_PRESS_WINDOW   = 3'd1,
        CFG_PRESSES_NEEDED = 3'd2,
        CFG_START_PERIOD   = 3'd3,
        CFG_STOP_PERIOD    = 3'd4,
        CFG_SWEEP_STEP     = 3'd5
    } t_cfg_idx;

    localparam logic [7:0]  RST_DEBOUNCE_LIMIT = 8'd30;
    localparam logic [15:0] RST_PRESS_WINDOW   = 16'd500;
    localparam logic [2:0]  RST_PRESSES_NEEDED = 3'd3;
    localparam logic [7:0]  RST_START_PERIOD   = 8'd167;
    localparam logic [7:0]  RST_STOP_PERIOD    = 8'd100;
    localparam logic [6:0]  RST_SWEEP_STEP     = 7'd2;

    localparam logic [2:0]  TALLY_MAX = 3'd7;
    localparam logic [7:0]  INTEG_MAX = 8'd255;

    typedef struct packed {
        logic [7:0]  debounce_limit;
        logic [15:0] press_window;
        logic [2:0]  presses_needed;
        logic [7:0]  start_period;
        logic [7:0]  stop_period;
        logic [6:0]  sweep_step;
    } t_cfg;

    // arming status from the press logic to the sweep
    typedef struct packed {
        logic armed;    // already armed before this item
        logic arm_now;  // arms on this item
    } t_arm;

endpackage

FILE: rtl/debounced_multi_press_siren.sv
// The result passes through the input register and then the output register.
// Throughput: one item per cycle while the result is not stalled; the state update is a single pass of small logic.
// A stalled result holds one more item in the input register, then the input stalls.
// Reset: synchronous, active low; clears handshake state and the block state, and loads
// the register reset values (limit 30, window 500, presses 3, periods 167/100, step 2).
module debounced_multi_press_siren (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_button_level,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_press_event,
    output logic                                o_armed,
    output logic                                o_tone_on,
    output logic [7:0]                          o_tone_top,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [dmps_pkg::CFG_IDX_WIDTH-1:0]  i_cfg_index,
    input  logic [dmps_pkg::CFG_DATA_WIDTH-1:0] i_cfg_data
);

    dmps_pkg::t_cfg cfg;
    dmps_pkg::t_arm arm;

    logic       r_in_valid;
    logic       r_in_level;
    logic       r_out_valid;
    logic       r_out_event;
    logic       r_out_armed;
    logic       r_out_tone_on;
    logic [7:0] r_out_top;
    logic       step;
    logic       n_event, n_armed, n_sounding;
    logic [7:0] n_held;

    assign step        = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall     = r_in_valid && r_out_valid && i_stall;
    assign o_cfg_ready = 1'b1;

    dmps_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    dmps_press u_press (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_button_level (r_in_level),
        .i_cfg          (cfg),
        .o_event        (n_event),
        .o_armed_next   (n_armed),
        .o_arm          (arm)
    );

    dmps_sweep u_sweep (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (step),
        .i_cfg           (cfg),
        .i_arm           (arm),
        .o_sounding_next (n_sounding),
        .o_held_next     (n_held)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_in_level <= i_button_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_event   <= n_event;
            r_out_armed   <= n_armed;
            r_out_tone_on <= n_armed & n_sounding;
            r_out_top     <= n_armed ? n_held : 8'd0;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_press_event = r_out_event;
    assign o_armed       = r_out_armed;
    assign o_tone_on     = r_out_tone_on;
    assign o_tone_top    = r_out_top;

    a_unarmed_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_armed |-> !o_tone_on && (o_tone_top == 8'd0))
        else $error("tone output before arming");

    a_step_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_valid)
        else $error("result lost after step");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_out_valid && i_stall && !step)
        else $error("input stalled without a blocked result");

endmodule

FILE: rtl/dmps_cfg.sv
module dmps_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [dmps_pkg::CFG_IDX_WIDTH-1:0]  i_cfg_index,
    input  logic [dmps_pkg::CFG_DATA_WIDTH-1:0] i_cfg_data,
    output dmps_pkg::t_cfg                      o_cfg
);

    dmps_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_limit <= dmps_pkg::RST_DEBOUNCE_LIMIT;
            r_cfg.press_window   <= dmps_pkg::RST_PRESS_WINDOW;
            r_cfg.presses_needed <= dmps_pkg::RST_PRESSES_NEEDED;
            r_cfg.start_period   <= dmps_pkg::RST_START_PERIOD;
            r_cfg.stop_period    <= dmps_pkg::RST_STOP_PERIOD;
            r_cfg.sweep_step     <= dmps_pkg::RST_SWEEP_STEP;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                dmps_pkg::CFG_DEBOUNCE_LIMIT: r_cfg.debounce_limit <= i_cfg_data[7:0];
                dmps_pkg::CFG_PRESS_WINDOW:   r_cfg.press_window   <= i_cfg_data;
                dmps_pkg::CFG_PRESSES_NEEDED: r_cfg.presses_needed <= i_cfg_data[2:0];
                dmps_pkg::CFG_START_PERIOD:   r_cfg.start_period   <= i_cfg_data[7:0];
                dmps_pkg::CFG_STOP_PERIOD:    r_cfg.stop_period    <= i_cfg_data[7:0];
                dmps_pkg::CFG_SWEEP_STEP:     r_cfg.sweep_step     <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/dmps_press.sv
module dmps_press (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_step,
    input  logic           i_button_level,
    input  dmps_pkg::t_cfg i_cfg,
    output logic           o_event,
    output logic           o_armed_next,
    output dmps_pkg::t_arm o_arm
);

    localparam int WW = dmps_pkg::WINDOW_WIDTH;

    logic [7:0]    r_integ, n_integ;
    logic          r_db, n_db;
    logic [2:0]    r_tally, n_tally;
    logic [WW-1:0] r_wleft, n_wleft;
    logic          r_armed;
    logic          pressed, accept, arm_now;
    logic [7:0]    integ_dn;

    always_comb begin
        pressed  = ~i_button_level;
        accept   = 1'b0;
        arm_now  = 1'b0;
        n_integ  = r_integ;
        n_db     = r_db;
        n_tally  = r_tally;
        n_wleft  = r_wleft;
        integ_dn = (r_integ != 8'd0) ? r_integ - 8'd1 : 8'd0;
        if (!r_armed) begin
            if (!r_db) begin
                if (pressed) begin
                    n_integ = (r_integ != dmps_pkg::INTEG_MAX) ? r_integ + 8'd1 : r_integ;
                    if (n_integ >= i_cfg.debounce_limit) begin
                        accept = 1'b1;
                        n_db   = 1'b1;
                    end
                end else begin
                    n_integ = integ_dn;
                end
            end else begin
                if (!pressed) begin
                    n_integ = integ_dn;
                    if (integ_dn == 8'd0) n_db = 1'b0;
                end else if (r_integ < i_cfg.debounce_limit) begin
                    n_integ = r_integ + 8'd1;
                end
            end
            if (accept) begin
                if (r_tally != dmps_pkg::TALLY_MAX) n_tally = r_tally + 3'd1;
                if (n_tally == 3'd1) n_wleft = WW'(i_cfg.press_window);
            end
            if (n_wleft != '0) begin
                if (n_tally == i_cfg.presses_needed) begin
                    arm_now = 1'b1;
                end else begin
                    n_wleft = n_wleft - WW'(1);
                end
            end else begin
                n_tally = 3'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= 8'd0;
            r_db    <= 1'b0;
            r_tally <= 3'd0;
            r_wleft <= '0;
            r_armed <= 1'b0;
        end else if (i_step) begin
            r_integ <= n_integ;
            r_db    <= n_db;
            r_tally <= n_tally;
            r_wleft <= n_wleft;
            r_armed <= r_armed | arm_now;
        end
    end

    assign o_event       = accept;
    assign o_armed_next  = r_armed | arm_now;
    assign o_arm.armed   = r_armed;
    assign o_arm.arm_now = arm_now;

    a_armed_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_armed |=> r_armed)
        else $error("armed flag dropped");

    a_no_event_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_armed |-> !accept && !arm_now)
        else $error("press logic active after arming");

endmodule

FILE: rtl/dmps_sweep.sv
module dmps_sweep (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_step,
    input  dmps_pkg::t_cfg i_cfg,
    input  dmps_pkg::t_arm i_arm,
    output logic           o_sounding_next,
    output logic [7:0]     o_held_next
);

    logic [7:0] r_period, n_period;
    logic       r_sounding, n_sounding;
    logic [7:0] r_held, n_held;
    logic [7:0] dec;

    always_comb begin
        n_period   = r_period;
        n_sounding = r_sounding;
        n_held     = r_held;
        dec        = (r_period > {1'b0, i_cfg.sweep_step})
                   ? r_period - {1'b0, i_cfg.sweep_step} : 8'd0;
        if (i_arm.armed) begin
            if (r_sounding) n_held = r_period - 8'd1;
            n_period = dec;
            if (dec <= i_cfg.stop_period) begin
                n_period   = i_cfg.start_period;
                n_sounding = ~r_sounding;
            end
        end else if (i_arm.arm_now) begin
            n_period   = i_cfg.start_period;
            n_held     = i_cfg.start_period - 8'd1;
            n_sounding = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period   <= dmps_pkg::RST_START_PERIOD;
            r_sounding <= 1'b1;
            r_held     <= dmps_pkg::RST_START_PERIOD - 8'd1;
        end else if (i_step) begin
            r_period   <= n_period;
            r_sounding <= n_sounding;
            r_held     <= n_held;
        end
    end

    assign o_sounding_next = n_sounding;
    assign o_held_next     = n_held;

endmodule

FILE: tb/sv/dmps_checker.sv
module dmps_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  logic                                i_button_level,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  logic                                i_press_event,
    input  logic                                i_armed,
    input  logic                                i_tone_on,
    input  logic [7:0]                          i_tone_top,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [dmps_pkg::CFG_IDX_WIDTH-1:0]  i_cfg_index,
    input  logic [dmps_pkg::CFG_DATA_WIDTH-1:0] i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_pending
);

    localparam int WW = dmps_pkg::WINDOW_WIDTH;

    typedef struct packed {
        logic       press_event;
        logic       armed;
        logic       tone_on;
        logic [7:0] tone_top;
    } t_tick_res;

    dmps_pkg::t_cfg          cfg;
    logic [7:0]              integ;
    logic                    deb_pressed;
    logic [2:0]              tally;
    logic [WW-1:0]           win_left;
    logic                    armed_q;
    logic [7:0]              period;
    logic                    sounding_q;
    logic [7:0]              top_q;
    t_tick_res               expected_ticks[$];

    task automatic advance_siren(input logic level, output t_tick_res res);
        logic pressed;
        logic ev;
        pressed = !level;
        ev = 1'b0;
        if (armed_q) begin
            if (sounding_q) begin
                top_q = period - 8'd1;
            end
            if (period > {1'b0, cfg.sweep_step}) begin
                period = period - {1'b0, cfg.sweep_step};
            end else begin
                period = 8'd0;
            end
            if (period <= cfg.stop_period) begin
                period = cfg.start_period;
                sounding_q = !sounding_q;
            end
        end else begin
            if (!deb_pressed) begin
                if (pressed) begin
                    if (integ != dmps_pkg::INTEG_MAX) begin
                        integ = integ + 8'd1;
                    end
                    if (integ >= cfg.debounce_limit) begin
                        ev = 1'b1;
                        deb_pressed = 1'b1;
                    end
                end else if (integ != 8'd0) begin
                    integ = integ - 8'd1;
                end
            end else begin
                if (!pressed) begin
                    if (integ != 8'd0) begin
                        integ = integ - 8'd1;
                    end
                    if (integ == 8'd0) begin
                        deb_pressed = 1'b0;
                    end
                end else if (integ < cfg.debounce_limit) begin
                    integ = integ + 8'd1;
                end
            end
            if (ev) begin
                if (tally != dmps_pkg::TALLY_MAX) begin
                    tally = tally + 3'd1;
                end
                if (tally == 3'd1) begin
                    win_left = WW'(cfg.press_window);
                end
            end
            if (win_left != '0) begin
                if (tally == cfg.presses_needed) begin
                    armed_q = 1'b1;
                    period = cfg.start_period;
                    top_q = cfg.start_period - 8'd1;
                    sounding_q = 1'b1;
                end else begin
                    win_left = win_left - WW'(1);
                end
            end else begin
                tally = 3'd0;
            end
        end
        res = '{ev, armed_q, armed_q & sounding_q, armed_q ? top_q : 8'd0};
    endtask

    always @(posedge i_clk) begin
        t_tick_res res;
        t_tick_res got;
        t_tick_res exp_res;
        if (!i_rst_n) begin
            cfg.debounce_limit = dmps_pkg::RST_DEBOUNCE_LIMIT;
            cfg.press_window = dmps_pkg::RST_PRESS_WINDOW;
            cfg.presses_needed = dmps_pkg::RST_PRESSES_NEEDED;
            cfg.start_period = dmps_pkg::RST_START_PERIOD;
            cfg.stop_period = dmps_pkg::RST_STOP_PERIOD;
            cfg.sweep_step = dmps_pkg::RST_SWEEP_STEP;
            integ = 8'd0;
            deb_pressed = 1'b0;
            tally = 3'd0;
            win_left = '0;
            armed_q = 1'b0;
            period = dmps_pkg::RST_START_PERIOD;
            sounding_q = 1'b1;
            top_q = dmps_pkg::RST_START_PERIOD - 8'd1;
            expected_ticks.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (dmps_pkg::t_cfg_idx'(i_cfg_index))
                    dmps_pkg::CFG_DEBOUNCE_LIMIT: cfg.debounce_limit = i_cfg_data[7:0];
                    dmps_pkg::CFG_PRESS_WINDOW:   cfg.press_window = i_cfg_data[15:0];
                    dmps_pkg::CFG_PRESSES_NEEDED: cfg.presses_needed = i_cfg_data[2:0];
                    dmps_pkg::CFG_START_PERIOD:   cfg.start_period = i_cfg_data[7:0];
                    dmps_pkg::CFG_STOP_PERIOD:    cfg.stop_period = i_cfg_data[7:0];
                    dmps_pkg::CFG_SWEEP_STEP:     cfg.sweep_step = i_cfg_data[6:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                advance_siren(i_button_level, res);
                expected_ticks.push_back(res);
            end
            if (i_out_valid && !i_out_stall) begin
                got = {i_press_event, i_armed, i_tone_on, i_tone_top};
                if (expected_ticks.size() == 0) begin
                    $display("%0t: expected none, actual event %0b armed %0b tone %0b top %0d",
                             $time, got.press_event, got.armed, got.tone_on, got.tone_top);
                    o_fail_count++;
                end else begin
                    exp_res = expected_ticks.pop_front();
                    if (got !== exp_res) begin
                        $display("%0t: tick result: expected event %0b armed %0b tone %0b top %0d",
                                 $time, exp_res.press_event, exp_res.armed, exp_res.tone_on,
                                 exp_res.tone_top);
                        $display("%0t: tick result: actual   event %0b armed %0b tone %0b top %0d",
                                 $time, got.press_event, got.armed, got.tone_on, got.tone_top);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = expected_ticks.size();
    end

endmodule

FILE: tb/sv/tb.sv
module tb;

    localparam int CYCLE_LIMIT = 400000;
    // button levels, first item in the top bit
    localparam logic [19:0] DIRECTED_LEVELS = 20'b1000_0101_1101_0011_0011;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_valid = 1'b0;
    logic                                o_stall;
    logic                                i_button_level = 1'b1;
    logic                                o_valid;
    logic                                i_stall = 1'b0;
    logic                                o_press_event;
    logic                                o_armed;
    logic                                o_tone_on;
    logic [7:0]                          o_tone_top;
    logic                                i_cfg_valid = 1'b0;
    logic                                o_cfg_ready;
    logic [dmps_pkg::CFG_IDX_WIDTH-1:0]  i_cfg_index = '0;
    logic [dmps_pkg::CFG_DATA_WIDTH-1:0] i_cfg_data = '0;

    int fail_count;
    int pending_ticks;
    int cycles = 0;
    int gap_calm = 0;
    int stall_left = 0;
    int stall_calm = 0;
    bit quiet = 1'b0;
    bit saw_armed = 1'b0;

    debounced_multi_press_siren u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_button_level (i_button_level),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_press_event  (o_press_event),
        .o_armed        (o_armed),
        .o_tone_on      (o_tone_on),
        .o_tone_top     (o_tone_top),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    dmps_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_button_level (i_button_level),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_press_event  (o_press_event),
        .i_armed        (o_armed),
        .i_tone_on      (o_tone_on),
        .i_tone_top     (o_tone_top),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending_ticks)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("debounced_multi_press_siren: mismatch");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (o_valid && !i_stall && o_armed) begin
            saw_armed <= 1'b1;
        end
    end

    always @(negedge i_clk) begin
        if (quiet || !i_rst_n) begin
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else begin
            i_stall <= 1'b0;
            if (stall_calm > 0) begin
                stall_calm--;
            end else if ($urandom_range(0, 3) == 0) begin
                stall_left = $urandom_range(1, 8);
                if ($urandom_range(0, 4) == 0) begin
                    stall_calm = $urandom_range(20, 60);
                end
            end
        end
    end

    // called and returns at a falling edge
    task automatic send_tick(input logic level);
        int gap;
        gap = 0;
        if (!quiet) begin
            if (gap_calm > 0) begin
                gap_calm--;
            end else if ($urandom_range(0, 4) == 0) begin
                gap = $urandom_range(1, 8);
                if ($urandom_range(0, 5) == 0) begin
                    gap_calm = $urandom_range(20, 60);
                end
            end
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_button_level <= level;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input dmps_pkg::t_cfg_idx idx,
                             input logic [dmps_pkg::CFG_DATA_WIDTH-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // waits for the block to drain, then loads all registers (junk in unused data bits)
    task automatic configure(input logic [7:0] lim, input logic [15:0] win,
                             input logic [2:0] need, input logic [7:0] start_p,
                             input logic [7:0] stop_p, input logic [6:0] step_p);
        logic [15:0] junk;
        i_valid <= 1'b0;
        while (pending_ticks != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        junk = 16'($urandom);
        write_reg(dmps_pkg::CFG_DEBOUNCE_LIMIT, {junk[15:8], lim});
        write_reg(dmps_pkg::CFG_PRESS_WINDOW, win);
        write_reg(dmps_pkg::CFG_PRESSES_NEEDED, {junk[15:3], need});
        write_reg(dmps_pkg::CFG_START_PERIOD, {junk[7:0], start_p});
        write_reg(dmps_pkg::CFG_STOP_PERIOD, {junk[11:4], stop_p});
        write_reg(dmps_pkg::CFG_SWEEP_STEP, {junk[12:4], step_p});
        i_cfg_valid <= 1'b0;
    endtask

    // presses with bounce, short presses and bursts of noise
    task automatic press_train(input int lim, input int count);
        int sent;
        int len;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 6) == 0) begin
                len = $urandom_range(1, 6);
                repeat (len) send_tick(1'($urandom_range(0, 1)));
                sent += len;
            end else begin
                len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, lim + 1)
                                                  : lim + $urandom_range(1, 4);
                repeat (len) send_tick($urandom_range(0, 9) == 0);
                sent += len;
                len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, lim + 1)
                                                  : lim + $urandom_range(1, 4);
                repeat (len) send_tick($urandom_range(0, 9) != 0);
                sent += len;
            end
        end
    endtask

    initial begin
        int lim;
        int n;
        int start_p;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        configure(8'd2, 16'd0, 3'd1, dmps_pkg::RST_START_PERIOD, dmps_pkg::RST_STOP_PERIOD,
                  dmps_pkg::RST_SWEEP_STEP);
        for (int b = $bits(DIRECTED_LEVELS) - 1; b >= 0; b--) begin
            send_tick(DIRECTED_LEVELS[b]);
        end

        // no arming in these phases: windows too short or presses_needed of 0
        configure(8'd1, 16'd1, 3'd2, 8'($urandom), 8'($urandom), 7'($urandom));
        press_train(1, 50);
        configure(8'd0, 16'd0, 3'd7, 8'($urandom), 8'($urandom), 7'($urandom));
        press_train(0, 50);
        lim = $urandom_range(1, 8);
        configure(8'(lim), 16'($urandom_range(1, 10)), 3'd7, 8'($urandom), 8'($urandom),
                  7'($urandom));
        press_train(lim, 80);
        configure(8'd255, 16'hFFFF, 3'd0, 8'($urandom), 8'($urandom), 7'($urandom));
        repeat (12) send_tick(1'b1);
        repeat (120) send_tick(1'b0);
        // limit drops below the count built up above
        configure(8'd2, 16'd100, 3'd0, 8'($urandom), 8'($urandom), 7'($urandom));
        press_train(2, 100);
        lim = $urandom_range(4, 20);
        configure(8'(lim), 16'($urandom_range(11, 60)), 3'd0, 8'($urandom), 8'($urandom),
                  7'($urandom));
        press_train(lim, 80);
        lim = $urandom_range(1, 5);
        configure(8'(lim), 16'($urandom_range(1, 10)), 3'd0, 8'($urandom), 8'($urandom),
                  7'($urandom));
        press_train(lim, 60);
        repeat (12) send_tick(1'b1);

        lim = $urandom_range(1, 6);
        configure(8'(lim),
                  ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'($urandom_range(200, 2000)),
                  3'($urandom_range(2, 7)), 8'($urandom_range(2, 255)),
                  8'($urandom_range(1, 100)), 7'($urandom_range(1, 64)));
        n = 0;
        while (!saw_armed && n < 600) begin
            press_train(lim, 10);
            n += 10;
        end

        // sweep settings once armed
        configure(8'($urandom), 16'($urandom), 3'($urandom), 8'd255, 8'd254, 7'd1);
        repeat (35) send_tick(1'($urandom_range(0, 1)));
        configure(8'($urandom), 16'($urandom), 3'($urandom), 8'd2, 8'd1, 7'd1);
        repeat (35) send_tick(1'($urandom_range(0, 1)));
        configure(8'($urandom), 16'($urandom), 3'($urandom), 8'd0, 8'd255, 7'd64);
        repeat (35) send_tick(1'($urandom_range(0, 1)));
        configure(8'($urandom), 16'($urandom), 3'($urandom), 8'd1, 8'd254, 7'd0);
        repeat (35) send_tick(1'($urandom_range(0, 1)));
        configure(8'($urandom), 16'($urandom), 3'($urandom), 8'd200, 8'd10, 7'd0);
        repeat (35) send_tick(1'($urandom_range(0, 1)));
        configure(8'($urandom), 16'($urandom), 3'($urandom), 8'd255, 8'd0, 7'd127);
        repeat (35) send_tick(1'($urandom_range(0, 1)));
        for (int p = 0; p < 2; p++) begin
            start_p = $urandom_range(2, 255);
            configure(8'($urandom), 16'($urandom), 3'($urandom), 8'(start_p),
                      8'($urandom_range(1, start_p - 1)), 7'($urandom_range(1, 64)));
            if (p == 1) begin
                quiet = 1'b1;
            end
            repeat (35) send_tick(1'($urandom_range(0, 1)));
        end

        i_valid <= 1'b0;
        while (pending_ticks != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (fail_count == 0 && pending_ticks == 0) begin
            $display("debounced_multi_press_siren: match");
        end else begin
            $display("debounced_multi_press_siren: mismatch");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/dmps_pkg.sv
rtl/dmps_cfg.sv
rtl/dmps_press.sv
rtl/dmps_sweep.sv
rtl/debounced_multi_press_siren.sv
tb/sv/dmps_checker.sv
tb/sv/tb.sv
